### hdl/wlsm_pkg.sv
package wlsm_pkg;

    // Number of phases that keep their own counters.
    localparam int PHASES = 4;
    localparam int PH_W   = (PHASES > 1) ? $clog2(PHASES) : 1;

    // Depth of the queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Hitch thresholds in microseconds.
    localparam logic [23:0] HITCH_25_US  = 24'd25000;
    localparam logic [23:0] HITCH_50_US  = 24'd50000;
    localparam logic [23:0] HITCH_100_US = 24'd100000;

    // Register reset values.
    localparam logic        ENABLED_RST  = 1'b1;
    localparam logic [31:0] SLOW_RST     = 32'd250000;
    localparam logic [47:0] INTERVAL_RST = 48'd300000000;

    localparam logic [31:0] MAX32 = '1;
    localparam logic [47:0] MAX48 = '1;

    // Operation codes of the input word.
    localparam logic OP_PHASE = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // Record kinds of the output word.
    localparam logic REC_FRAME = 1'b0;
    localparam logic REC_PHASE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ENABLED  = 2'd0,
        CFG_SLOW     = 2'd1,
        CFG_INTERVAL = 2'd2
    } t_cfg_idx;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRAME_SUM,
        ST_PHASE_SUM
    } t_back_state;

    // A classified word as it travels through the queue.
    typedef struct packed {
        logic            is_frame;
        logic [PH_W-1:0] ph;
        logic            slow;
        logic [2:0]      hitch;
        logic [31:0]     ticks;
        logic [31:0]     units;
        logic [23:0]     fus;
        logic [47:0]     now;
    } t_item;

    // Queue write request from the front part.
    typedef struct packed {
        logic push;
    } t_q_wr;

    // Saturating increment of a 32-bit counter.
    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        logic [31:0] r;
        r = (a == MAX32) ? a : a + 32'd1;
        return r;
    endfunction

    // Saturating add into a 48-bit sum.
    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? MAX48 : s[47:0];
    endfunction

endpackage

### hdl/wlsm_queue.sv
module wlsm_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wlsm_pkg::t_item     i_data,
    output logic                o_full,
    output logic                o_valid,
    output wlsm_pkg::t_item     o_data,
    input  logic                i_pop
);
    import wlsm_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage of queued words.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hdl/wlsm_front.sv
module wlsm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input word channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_op,
    input  logic [1:0]          i_phase_index,
    input  logic [31:0]         i_sample_ticks,
    input  logic [31:0]         i_sample_units,
    input  logic [23:0]         i_frame_us,
    input  logic [47:0]         i_now_ticks,
    // Configuration writes.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_data,
    // Queue write side.
    output wlsm_pkg::t_q_wr     o_q_wr,
    input  logic                i_q_full,
    output wlsm_pkg::t_item     o_q_data,
    output logic [47:0]         o_interval
);
    import wlsm_pkg::*;

    logic        r_enabled;
    logic [31:0] r_slow_ticks;
    logic [47:0] r_interval;
    logic        keep;
    t_cfg_idx    cfg_idx;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign o_interval  = r_interval;
    assign cfg_idx     = t_cfg_idx'(i_cfg_index);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= ENABLED_RST;
            r_slow_ticks <= SLOW_RST;
            r_interval   <= INTERVAL_RST;
        end else if (i_cfg_valid) begin
            unique case (cfg_idx)
                CFG_ENABLED:  r_enabled    <= i_cfg_data[0];
                CFG_SLOW:     r_slow_ticks <= i_cfg_data[31:0];
                CFG_INTERVAL: r_interval   <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Classify the word: drop it when disabled or when its phase does not exist.
    always_comb begin
        keep = r_enabled && ((i_op == OP_FRAME) || (int'(i_phase_index) < PHASES));
        o_q_wr.push = i_in_valid && !i_q_full && keep;
        o_q_data.is_frame = (i_op == OP_FRAME);
        o_q_data.ph       = PH_W'(i_phase_index);
        o_q_data.slow     = (i_sample_ticks >= r_slow_ticks);
        o_q_data.hitch[0] = (i_frame_us >= HITCH_25_US);
        o_q_data.hitch[1] = (i_frame_us >= HITCH_50_US);
        o_q_data.hitch[2] = (i_frame_us >= HITCH_100_US);
        o_q_data.ticks    = i_sample_ticks;
        o_q_data.units    = i_sample_units;
        o_q_data.fus      = i_frame_us;
        o_q_data.now      = i_now_ticks;
    end

endmodule

### hdl/wlsm_back.sv
module wlsm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Queue read side.
    input  logic                i_q_valid,
    input  wlsm_pkg::t_item     i_q_data,
    output logic                o_q_pop,
    input  logic [47:0]         i_interval,
    // Result word channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_record_kind,
    output logic [1:0]          o_phase_number,
    output logic [31:0]         o_event_count,
    output logic [31:0]         o_slow_or_hitch25,
    output logic [31:0]         o_hitch50_count,
    output logic [31:0]         o_hitch100_count,
    output logic [47:0]         o_total_time,
    output logic [31:0]         o_max_time,
    output logic [47:0]         o_unit_total,
    output logic [47:0]         o_elapsed_ticks,
    output logic                o_last
);
    import wlsm_pkg::*;

    // Per-phase counters.
    logic [31:0] r_calls [PHASES];
    logic [31:0] r_slow  [PHASES];
    logic [47:0] r_tsum  [PHASES];
    logic [31:0] r_tmax  [PHASES];
    logic [47:0] r_usum  [PHASES];
    // Frame counters and window.
    logic [31:0] r_fcount;
    logic [47:0] r_fsum;
    logic [23:0] r_fmax;
    logic [31:0] r_hitch [3];
    logic [47:0] r_win_start;
    logic [47:0] r_win_end;
    logic        r_win_open;
    logic [47:0] r_elapsed;

    t_back_state     r_state, n_state;
    logic [PH_W-1:0] r_rep_ph, n_rep_ph;

    logic            do_phase, do_frame, report;
    logic            ld, ld_sum, ld_phase, clr;
    logic [PH_W-1:0] addr;
    logic [48:0]     end_sum;
    logic [47:0]     end_new, end_eff, start_eff;

    // Output register.
    logic        r_out_valid;
    logic        r_kind;
    logic [1:0]  r_phnum;
    logic [31:0] r_count, r_slow_h25, r_h50, r_h100, r_max;
    logic [47:0] r_total, r_units, r_out_elapsed;
    logic        r_last;

    assign ld   = !r_out_valid || !i_out_stall;
    assign addr = (r_state == ST_PHASE_SUM) ? r_rep_ph : i_q_data.ph;

    // Window end test for a frame, with the window opened by this frame if none is open.
    always_comb begin
        end_sum   = {1'b0, i_q_data.now} + {1'b0, i_interval};
        end_new   = end_sum[48] ? MAX48 : end_sum[47:0];
        end_eff   = r_win_open ? r_win_end : end_new;
        start_eff = r_win_open ? r_win_start : i_q_data.now;
        report    = (i_q_data.now >= end_eff);
    end

    // Report sequencer: next state and control.
    always_comb begin
        n_state  = r_state;
        n_rep_ph = r_rep_ph;
        o_q_pop  = 1'b0;
        do_phase = 1'b0;
        do_frame = 1'b0;
        ld_sum   = 1'b0;
        ld_phase = 1'b0;
        clr      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.is_frame) begin
                        do_frame = 1'b1;
                        if (report) begin
                            n_state = ST_FRAME_SUM;
                        end
                    end else begin
                        do_phase = 1'b1;
                    end
                end
            end
            ST_FRAME_SUM: begin
                if (ld) begin
                    ld_sum   = 1'b1;
                    n_rep_ph = '0;
                    n_state  = ST_PHASE_SUM;
                end
            end
            ST_PHASE_SUM: begin
                if (ld) begin
                    ld_phase = 1'b1;
                    if (r_rep_ph == PH_W'(PHASES - 1)) begin
                        clr     = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_rep_ph = r_rep_ph + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rep_ph <= '0;
        end else begin
            r_state  <= n_state;
            r_rep_ph <= n_rep_ph;
        end
    end

    // Counter and window updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            for (int p = 0; p < PHASES; p++) begin
                r_calls[p] <= '0;
                r_slow[p]  <= '0;
                r_tsum[p]  <= '0;
                r_tmax[p]  <= '0;
                r_usum[p]  <= '0;
            end
            r_fcount <= '0;
            r_fsum   <= '0;
            r_fmax   <= '0;
            for (int h = 0; h < 3; h++) begin
                r_hitch[h] <= '0;
            end
        end else begin
            if (do_phase) begin
                r_calls[addr] <= sat_inc32(r_calls[addr]);
                if (i_q_data.slow) begin
                    r_slow[addr] <= sat_inc32(r_slow[addr]);
                end
                r_tsum[addr] <= sat_add48(r_tsum[addr], {16'd0, i_q_data.ticks});
                if (i_q_data.ticks > r_tmax[addr]) begin
                    r_tmax[addr] <= i_q_data.ticks;
                end
                r_usum[addr] <= sat_add48(r_usum[addr], {16'd0, i_q_data.units});
            end
            if (do_frame) begin
                r_fcount <= sat_inc32(r_fcount);
                r_fsum   <= sat_add48(r_fsum, {24'd0, i_q_data.fus});
                if (i_q_data.fus > r_fmax) begin
                    r_fmax <= i_q_data.fus;
                end
                for (int h = 0; h < 3; h++) begin
                    if (i_q_data.hitch[h]) begin
                        r_hitch[h] <= sat_inc32(r_hitch[h]);
                    end
                end
            end
        end
    end

    // The window reopens at the reporting frame; elapsed time is kept for the report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= '0;
            r_win_end   <= '0;
            r_win_open  <= 1'b0;
        end else if (do_frame) begin
            r_win_open <= 1'b1;
            if (!r_win_open || report) begin
                r_win_start <= i_q_data.now;
                r_win_end   <= end_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_frame && report) begin
            r_elapsed <= i_q_data.now - start_eff;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld) begin
            r_out_valid <= ld_sum || ld_phase;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (ld_sum) begin
            r_kind        <= REC_FRAME;
            r_phnum       <= 2'd0;
            r_count       <= r_fcount;
            r_slow_h25    <= r_hitch[0];
            r_h50         <= r_hitch[1];
            r_h100        <= r_hitch[2];
            r_total       <= r_fsum;
            r_max         <= {8'd0, r_fmax};
            r_units       <= '0;
            r_out_elapsed <= r_elapsed;
            r_last        <= 1'b0;
        end else if (ld_phase) begin
            r_kind        <= REC_PHASE;
            r_phnum       <= 2'(r_rep_ph);
            r_count       <= r_calls[addr];
            r_slow_h25    <= r_slow[addr];
            r_h50         <= '0;
            r_h100        <= '0;
            r_total       <= r_tsum[addr];
            r_max         <= r_tmax[addr];
            r_units       <= r_usum[addr];
            r_out_elapsed <= r_elapsed;
            r_last        <= (r_rep_ph == PH_W'(PHASES - 1));
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_record_kind     = r_kind;
    assign o_phase_number    = r_phnum;
    assign o_event_count     = r_count;
    assign o_slow_or_hitch25 = r_slow_h25;
    assign o_hitch50_count   = r_h50;
    assign o_hitch100_count  = r_h100;
    assign o_total_time      = r_total;
    assign o_max_time        = r_max;
    assign o_unit_total      = r_units;
    assign o_elapsed_ticks   = r_out_elapsed;
    assign o_last            = r_last;

endmodule

### hdl/windowed_latency_stats_monitor_core.sv
// Windowed latency statistics monitor.
// Input words arrive on i_in_valid / o_in_stall: a phase sample (i_op low) adds to the
// counters of its phase, a frame event (i_op high) adds to the frame counters and may
// close the reporting window. Configuration is written on i_cfg_valid / o_cfg_ready
// (always ready); the user must do so only while the block is idle, which the block
// itself does not enforce. A word enters a two-entry queue the cycle it is accepted;
// the back part takes one queued word per cycle, so phase samples and non-reporting
// frames sustain one word a cycle. A frame that closes the window starts a report: one
// frame summary word and one word per phase leave through the output register on
// o_out_valid / i_out_stall, one per cycle while the receiver does not stall.
// While a report is emitted the back part takes no queued word; once the queue fills,
// o_in_stall rises. A report thus holds the back part in the frame summary state and one
// phase state per phase, plus any output stall. A stalled output word holds its value.
// Synchronous reset (i_rst_n low) clears all counters and the window, empties the queue
// and restores the register defaults: enabled, slow threshold 250000, window 300000000.
module windowed_latency_stats_monitor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [1:0]  i_phase_index,
    input  logic [31:0] i_sample_ticks,
    input  logic [31:0] i_sample_units,
    input  logic [23:0] i_frame_us,
    input  logic [47:0] i_now_ticks,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_record_kind,
    output logic [1:0]  o_phase_number,
    output logic [31:0] o_event_count,
    output logic [31:0] o_slow_or_hitch25,
    output logic [31:0] o_hitch50_count,
    output logic [31:0] o_hitch100_count,
    output logic [47:0] o_total_time,
    output logic [31:0] o_max_time,
    output logic [47:0] o_unit_total,
    output logic [47:0] o_elapsed_ticks,
    output logic        o_last
);
    import wlsm_pkg::*;

    t_q_wr       q_wr;
    t_item       q_in, q_out;
    logic        q_full, q_valid, q_pop;
    logic [47:0] interval;

    // Front part: configuration registers and classification.
    wlsm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_phase_index  (i_phase_index),
        .i_sample_ticks (i_sample_ticks),
        .i_sample_units (i_sample_units),
        .i_frame_us     (i_frame_us),
        .i_now_ticks    (i_now_ticks),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_q_wr         (q_wr),
        .i_q_full       (q_full),
        .o_q_data       (q_in),
        .o_interval     (interval)
    );

    // Queue between the parts.
    wlsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_wr.push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    // Back part: counters, window and report sequencer.
    wlsm_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_data          (q_out),
        .o_q_pop           (q_pop),
        .i_interval        (interval),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_record_kind     (o_record_kind),
        .o_phase_number    (o_phase_number),
        .o_event_count     (o_event_count),
        .o_slow_or_hitch25 (o_slow_or_hitch25),
        .o_hitch50_count   (o_hitch50_count),
        .o_hitch100_count  (o_hitch100_count),
        .o_total_time      (o_total_time),
        .o_max_time        (o_max_time),
        .o_unit_total      (o_unit_total),
        .o_elapsed_ticks   (o_elapsed_ticks),
        .o_last            (o_last)
    );

endmodule

### hdl/wlsm_checker.sv
module wlsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_record_kind,
    input logic [31:0] o_event_count,
    input logic [31:0] o_slow_or_hitch25,
    input logic [31:0] o_hitch50_count,
    input logic [31:0] o_hitch100_count,
    input logic [47:0] o_unit_total,
    input logic [47:0] o_elapsed_ticks,
    input logic        o_last
);
    import wlsm_pkg::*;

    // The last word of a report is always a phase word.
    a_last_is_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_record_kind == REC_PHASE)
        else $error("last word of a report is not a phase word");

    // A frame summary carries no units, is never last, and has nested hitch counts within its frame count.
    a_frame_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind == REC_FRAME |->
            o_unit_total == '0 && !o_last &&
            o_hitch100_count <= o_hitch50_count &&
            o_hitch50_count <= o_slow_or_hitch25 &&
            o_slow_or_hitch25 <= o_event_count)
        else $error("inconsistent frame summary");

    // Phase words carry no hitch counts and no more slow calls than calls.
    a_phase_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind == REC_PHASE |->
            o_hitch50_count == '0 && o_hitch100_count == '0 &&
            o_slow_or_hitch25 <= o_event_count)
        else $error("inconsistent phase word");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_event_count) && $stable(o_elapsed_ticks) &&
            $stable(o_last))
        else $error("stalled output word changed");

endmodule

bind windowed_latency_stats_monitor_core wlsm_checker u_wlsm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_record_kind     (o_record_kind),
    .o_event_count     (o_event_count),
    .o_slow_or_hitch25 (o_slow_or_hitch25),
    .o_hitch50_count   (o_hitch50_count),
    .o_hitch100_count  (o_hitch100_count),
    .o_unit_total      (o_unit_total),
    .o_elapsed_ticks   (o_elapsed_ticks),
    .o_last            (o_last)
);

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wlsm_pkg::*;

    localparam int          RUN_LIMIT    = 200000;
    localparam int          SETTLE       = 10;
    localparam int          HOLD_CYCLES  = 120;
    localparam int          MAX_SHOWN    = 10;
    localparam logic [23:0] HITCH_A      = 24'd25000;
    localparam logic [23:0] HITCH_B      = 24'd50000;
    localparam logic [23:0] HITCH_C      = 24'd100000;
    localparam logic [31:0] TOP32        = 32'hFFFF_FFFF;
    localparam logic [47:0] TOP48        = 48'hFFFF_FFFF_FFFF;
    localparam logic [23:0] TOP24        = 24'hFF_FFFF;

    // One input word as it is offered to the block.
    typedef struct packed {
        logic        op;
        logic [1:0]  phase;
        logic [31:0] ticks;
        logic [31:0] units;
        logic [23:0] fus;
        logic [47:0] now;
    } t_word;

    // One report record as it leaves the block.
    typedef struct packed {
        logic        kind;
        logic [1:0]  phase;
        logic [31:0] count;
        logic [31:0] slow_h25;
        logic [31:0] h50;
        logic [31:0] h100;
        logic [47:0] total;
        logic [31:0] peak;
        logic [47:0] units;
        logic [47:0] elapsed;
        logic        last;
    } t_rec;

    // Window statistics predictor plus the list of report records still owed.
    class report_tracker;
        logic        en;
        logic [31:0] slow_thr;
        logic [47:0] interval;
        logic [31:0] calls     [PHASES];
        logic [31:0] slow_hits [PHASES];
        logic [47:0] tick_sum  [PHASES];
        logic [31:0] tick_max  [PHASES];
        logic [47:0] unit_sum  [PHASES];
        logic [31:0] frames;
        logic [47:0] ftime_sum;
        logic [23:0] ftime_max;
        logic [31:0] hitches   [3];
        logic [47:0] win_start;
        logic [47:0] win_end;
        logic        win_open;
        t_rec        owed_records[$];
        int          words;
        int          frames_counted;
        int          reports;
        int          records;
        int          mismatches;

        function new();
            en        = ENABLED_RST;
            slow_thr  = SLOW_RST;
            interval  = INTERVAL_RST;
            win_start = '0;
            win_end   = '0;
            win_open  = 1'b0;
            clear_window();
        endfunction

        function logic [31:0] bump32(logic [31:0] a);
            return (a == TOP32) ? a : a + 32'd1;
        endfunction

        function logic [47:0] add48(logic [47:0] a, logic [47:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[48] ? TOP48 : s[47:0];
        endfunction

        function void clear_window();
            for (int p = 0; p < PHASES; p++) begin
                calls[p]     = '0;
                slow_hits[p] = '0;
                tick_sum[p]  = '0;
                tick_max[p]  = '0;
                unit_sum[p]  = '0;
            end
            frames    = '0;
            ftime_sum = '0;
            ftime_max = '0;
            for (int h = 0; h < 3; h++) begin
                hitches[h] = '0;
            end
        endfunction

        function void start_window(logic [47:0] now);
            win_start = now;
            win_end   = add48(now, interval);
            win_open  = 1'b1;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [47:0] data);
            case (idx)
                CFG_ENABLED:  en = data[0];
                CFG_SLOW:     slow_thr = data[31:0];
                CFG_INTERVAL: interval = data;
                default: ;
            endcase
        endfunction

        // Accumulate one accepted word; a frame that reaches the window end owes a report.
        function void note_word(t_word w);
            t_rec        r;
            logic [47:0] elapsed;
            words++;
            if (!en) return;
            if (w.op == OP_PHASE) begin
                if (w.phase >= PHASES) return;
                calls[w.phase] = bump32(calls[w.phase]);
                if (w.ticks >= slow_thr) slow_hits[w.phase] = bump32(slow_hits[w.phase]);
                tick_sum[w.phase] = add48(tick_sum[w.phase], {16'd0, w.ticks});
                if (w.ticks > tick_max[w.phase]) tick_max[w.phase] = w.ticks;
                unit_sum[w.phase] = add48(unit_sum[w.phase], {16'd0, w.units});
                return;
            end

            frames_counted++;
            if (!win_open) start_window(w.now);
            frames    = bump32(frames);
            ftime_sum = add48(ftime_sum, {24'd0, w.fus});
            if (w.fus > ftime_max) ftime_max = w.fus;
            if (w.fus >= HITCH_A) hitches[0] = bump32(hitches[0]);
            if (w.fus >= HITCH_B) hitches[1] = bump32(hitches[1]);
            if (w.fus >= HITCH_C) hitches[2] = bump32(hitches[2]);
            if (w.now < win_end) return;

            // Frame summary first, then one record per phase, the last one flagged.
            elapsed    = w.now - win_start;
            r          = '0;
            r.kind     = REC_FRAME;
            r.count    = frames;
            r.slow_h25 = hitches[0];
            r.h50      = hitches[1];
            r.h100     = hitches[2];
            r.total    = ftime_sum;
            r.peak     = {8'd0, ftime_max};
            r.elapsed  = elapsed;
            owed_records.push_back(r);
            for (int p = 0; p < PHASES; p++) begin
                r          = '0;
                r.kind     = REC_PHASE;
                r.phase    = p[1:0];
                r.count    = calls[p];
                r.slow_h25 = slow_hits[p];
                r.total    = tick_sum[p];
                r.peak     = tick_max[p];
                r.units    = unit_sum[p];
                r.elapsed  = elapsed;
                r.last     = (p == PHASES - 1);
                owed_records.push_back(r);
            end
            reports++;
            clear_window();
            start_window(w.now);
        endfunction

        function string to_text(t_rec r);
            return $sformatf({"kind=%0d ph=%0d cnt=%0d slow/h25=%0d h50=%0d h100=%0d ",
                              "total=%0d max=%0d units=%0d elapsed=%0d last=%0d"},
                             r.kind, r.phase, r.count, r.slow_h25, r.h50, r.h100,
                             r.total, r.peak, r.units, r.elapsed, r.last);
        endfunction

        // Compare one accepted record with the oldest one owed.
        function void check_record(t_rec got);
            t_rec want;
            records++;
            if (owed_records.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("ERROR: record %0d arrived with none owed: %s", records,
                             to_text(got));
                return;
            end
            want = owed_records.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("ERROR: record %0d differs", records);
                    $display("  expected %s", to_text(want));
                    $display("  actual   %s", to_text(got));
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_op;
    logic [1:0]  i_phase_index;
    logic [31:0] i_sample_ticks;
    logic [31:0] i_sample_units;
    logic [23:0] i_frame_us;
    logic [47:0] i_now_ticks;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [47:0] i_cfg_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_record_kind;
    logic [1:0]  o_phase_number;
    logic [31:0] o_event_count;
    logic [31:0] o_slow_or_hitch25;
    logic [31:0] o_hitch50_count;
    logic [31:0] o_hitch100_count;
    logic [47:0] o_total_time;
    logic [31:0] o_max_time;
    logic [47:0] o_unit_total;
    logic [47:0] o_elapsed_ticks;
    logic        o_last;

    report_tracker sb;
    logic [47:0]   ts_now;
    bit            rx_pattern;
    bit            hold_req;
    int            hold_left;
    bit            run_stall;
    int            run_left;
    int            cycle_count;
    int            stall_cycles;
    int            settings_used;

    windowed_latency_stats_monitor_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_phase_index     (i_phase_index),
        .i_sample_ticks    (i_sample_ticks),
        .i_sample_units    (i_sample_units),
        .i_frame_us        (i_frame_us),
        .i_now_ticks       (i_now_ticks),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_record_kind     (o_record_kind),
        .o_phase_number    (o_phase_number),
        .o_event_count     (o_event_count),
        .o_slow_or_hitch25 (o_slow_or_hitch25),
        .o_hitch50_count   (o_hitch50_count),
        .o_hitch100_count  (o_hitch100_count),
        .o_total_time      (o_total_time),
        .o_max_time        (o_max_time),
        .o_unit_total      (o_unit_total),
        .o_elapsed_ticks   (o_elapsed_ticks),
        .o_last            (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Output side: check each accepted record, then pick the next stall value.
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_record('{o_record_kind, o_phase_number, o_event_count, o_slow_or_hitch25,
                              o_hitch50_count, o_hitch100_count, o_total_time, o_max_time,
                              o_unit_total, o_elapsed_ticks, o_last});
        if (i_in_valid && o_in_stall) stall_cycles++;

        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!rx_pattern) begin
            i_out_stall <= 1'b0;
        end else begin
            if (run_left == 0) begin
                run_stall = !run_stall;
                run_left  = run_stall ? $urandom_range(1, 4) : $urandom_range(1, 8);
            end
            run_left--;
            i_out_stall <= run_stall;
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ERROR: run limit of %0d cycles reached", RUN_LIMIT);
        $display("windowed_latency_stats_monitor_core test failed");
        $finish;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // Random word; frames mostly move time forward so windows close regularly.
    function automatic t_word make_word(input int frame_pct, input longint unsigned step_max);
        t_word           w;
        longint unsigned r;
        w.op    = ($urandom_range(0, 99) < frame_pct) ? OP_FRAME : OP_PHASE;
        w.phase = 2'($urandom_range(0, PHASES - 1));
        case ($urandom_range(0, 3))
            0: w.ticks = sb.slow_thr - 32'd1 + 32'($urandom_range(0, 2));
            1: w.ticks = 32'($urandom_range(0, 1000));
            default: w.ticks = $urandom;
        endcase
        w.units = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 255)) : $urandom;
        case ($urandom_range(0, 7))
            0: w.fus = HITCH_A - 24'd1 + 24'($urandom_range(0, 2));
            1: w.fus = HITCH_B - 24'd1 + 24'($urandom_range(0, 2));
            2: w.fus = HITCH_C - 24'd1 + 24'($urandom_range(0, 2));
            3: w.fus = 24'($urandom);
            4: w.fus = '0;
            default: w.fus = 24'($urandom_range(0, 9999999));
        endcase
        if (w.op == OP_PHASE) begin
            w.now = rand48();
        end else if ($urandom_range(0, 15) == 0) begin
            // Out-of-order timestamp slightly in the past.
            w.now = ts_now - 48'($urandom_range(0, 1000));
        end else begin
            r      = {$urandom, $urandom};
            ts_now = ts_now + 48'(r % (step_max + 1));
            w.now  = ts_now;
        end
        return w;
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic push_word(input t_word w);
        i_in_valid     <= 1'b1;
        i_op           <= w.op;
        i_phase_index  <= w.phase;
        i_sample_ticks <= w.ticks;
        i_sample_units <= w.units;
        i_frame_us     <= w.fus;
        i_now_ticks    <= w.now;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(w);
    endtask

    task automatic offer(input logic op, input logic [1:0] ph, input logic [31:0] ticks,
                         input logic [31:0] units, input logic [23:0] fus,
                         input logic [47:0] now);
        push_word('{op, ph, ticks, units, fus, now});
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic program_regs(input logic [47:0] en_word, input logic [47:0] slow_word,
                                input logic [47:0] intv_word);
        put_reg(CFG_ENABLED, en_word);
        put_reg(CFG_SLOW, slow_word);
        put_reg(CFG_INTERVAL, intv_word);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Wait for every owed record, then let queued words without results drain.
    task automatic wait_idle();
        while (sb.owed_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Random words in bursts, optionally with gaps between bursts.
    task automatic run_random(input int n, input int frame_pct, input longint unsigned step_max,
                              input bit gaps);
        int burst_left;
        burst_left = $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
            push_word(make_word(frame_pct, step_max));
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if (gaps) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        sb             = new();
        ts_now         = 48'd600001005;
        rx_pattern     = 1'b0;
        hold_req       = 1'b0;
        hold_left      = 0;
        run_stall      = 1'b0;
        run_left       = 0;
        stall_cycles   = 0;
        settings_used  = 1;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_op           = OP_PHASE;
        i_phase_index  = '0;
        i_sample_ticks = '0;
        i_sample_units = '0;
        i_frame_us     = '0;
        i_now_ticks    = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_ENABLED;
        i_cfg_data     = '0;
        i_out_stall    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: field extremes, slow threshold edges, each hitch threshold.
        offer(OP_PHASE, 2'd0, 32'd0, 32'd0, TOP24, TOP48);
        offer(OP_PHASE, 2'd3, TOP32, TOP32, 24'd0, 48'd0);
        offer(OP_PHASE, 2'd1, 32'd249999, 32'd7, 24'd1, 48'd5);
        offer(OP_PHASE, 2'd2, 32'd250000, 32'd9, 24'd2, 48'd6);
        offer(OP_FRAME, 2'd3, TOP32, TOP32, 24'd0, 48'd1000);
        offer(OP_FRAME, 2'd0, 32'd0, 32'd0, HITCH_A - 24'd1, 48'd2000);
        offer(OP_FRAME, 2'd1, 32'd1, 32'd1, HITCH_A, 48'd3000);
        offer(OP_FRAME, 2'd2, 32'd2, 32'd2, HITCH_B, 48'd4000);
        offer(OP_FRAME, 2'd3, 32'd3, 32'd3, HITCH_C, 48'd5000);
        // Frame time above range just before the window end, then the reporting frame.
        offer(OP_FRAME, 2'd0, 32'd4, 32'd4, TOP24, 48'd300000999);
        offer(OP_FRAME, 2'd1, 32'd5, 32'd5, 24'd9999999, 48'd300001000);
        i_in_valid <= 1'b0;
        wait_idle();

        // Zero slow threshold and zero window length.
        program_regs(48'd1, 48'd0, 48'd0);
        offer(OP_PHASE, 2'd2, 32'd0, 32'd3, 24'd0, 48'd0);
        offer(OP_FRAME, 2'd0, 32'd0, 32'd0, 24'd40000, 48'd600001000);
        offer(OP_FRAME, 2'd0, 32'd0, 32'd0, 24'd60000, 48'd600001000);
        offer(OP_FRAME, 2'd0, 32'd0, 32'd0, 24'd120000, 48'd600001005);
        i_in_valid <= 1'b0;
        wait_idle();

        // Disabled: nothing may change, not even with a timestamp at the top.
        program_regs({rand48() & ~48'd1}, 48'd1, 48'd1000);
        offer(OP_PHASE, 2'd1, TOP32, TOP32, TOP24, TOP48);
        offer(OP_FRAME, 2'd2, TOP32, TOP32, TOP24, TOP48);
        offer(OP_FRAME, 2'd3, 32'd0, 32'd0, 24'd0, 48'd0);
        i_in_valid <= 1'b0;
        wait_idle();

        // Moderate windows with idling on both sides.
        rx_pattern = 1'b1;
        program_regs(48'd1, 48'd250000, 48'd1000);
        run_random(70, 40, 400, 1'b1);
        wait_idle();

        // Smallest threshold and window, back to back with no idling.
        rx_pattern = 1'b0;
        program_regs(48'd1, 48'd1, 48'd1);
        run_random(40, 40, 3, 1'b0);
        wait_idle();

        // Receiver holds off while reporting frames keep coming, so the input stalls.
        hold_req = 1'b1;
        run_random(30, 85, 2, 1'b0);
        wait_idle();

        // Large timestamps and random registers with junk in the unused upper bits.
        rx_pattern = 1'b1;
        ts_now     = ts_now + (rand48() >> 1);
        program_regs({rand48() | 48'd1}, rand48(), {16'd0, $urandom} | 48'd1);
        run_random(60, 40, 64'd2147483648, 1'b1);
        wait_idle();

        program_regs(48'd1, 48'($urandom_range(1, 1000)), 48'd300);
        run_random(50, 40, 100, 1'b1);
        wait_idle();

        // Top threshold and longest window; the end saturates, so this goes last.
        program_regs(48'd1, {16'd0, TOP32}, TOP48);
        offer(OP_PHASE, 2'd1, TOP32 - 32'd1, 32'd1, 24'd0, 48'd0);
        offer(OP_PHASE, 2'd1, TOP32, 32'd1, 24'd0, 48'd0);
        offer(OP_FRAME, 2'd0, 32'd0, 32'd0, 24'd30000, TOP48 - 48'd1);
        offer(OP_FRAME, 2'd0, 32'd0, 32'd0, 24'd70000, TOP48 - 48'd1);
        offer(OP_FRAME, 2'd0, 32'd0, 32'd0, 24'd10, TOP48);
        i_in_valid <= 1'b0;
        wait_idle();

        $display("Covered %0d words (%0d frames counted) over %0d register settings.",
                 sb.words, sb.frames_counted, settings_used);
        $display("Checked %0d records from %0d reports; input stalled %0d cycles; %0d %s",
                 sb.records, sb.reports, stall_cycles, sb.mismatches, "mismatches.");
        if (sb.mismatches == 0 && sb.owed_records.size() == 0) begin
            $display("windowed_latency_stats_monitor_core test passed");
        end else begin
            $display("windowed_latency_stats_monitor_core test failed");
        end
        $finish;
    end

endmodule
